[src/sphere_pixel_nest_ring_convert_core_assert.svh]
// Assertion macros shared by the sphere pixel conversion RTL.
// Depends on nothing; the including module must have clock and reset signals.
`ifndef SPHERE_PIXEL_NEST_RING_CONVERT_CORE_ASSERT_SVH
`define SPHERE_PIXEL_NEST_RING_CONVERT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SPRNR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication with a fixed delay in cycles, disabled while reset is high.
`define SPRNR_ASSERT_DELAY(label, ante, dly, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |-> ##(dly) (cons)) else $error(msg);

`endif

[src/sprnr_pkg.sv]
// Package for the sphere pixel nested/ring converter: widths, face tables,
// request type and the bit interleave helpers. Depends on nothing.
package sprnr_pkg;

   localparam int PIX_W         = 62;
   localparam int SIDE_W        = 30;
   localparam int MAX_ORDER_DEF = 29;

   localparam logic ACT_NEST_TO_RING = 1'b0;
   localparam logic ACT_RING_TO_NEST = 1'b1;

   localparam logic [63:0] M1  = 64'h5555555555555555;
   localparam logic [63:0] M2  = 64'h3333333333333333;
   localparam logic [63:0] M4  = 64'h0f0f0f0f0f0f0f0f;
   localparam logic [63:0] M8  = 64'h00ff00ff00ff00ff;
   localparam logic [63:0] M16 = 64'h0000ffff0000ffff;

   localparam logic [2:0] RING_ROW [12] = '{3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3,
                                            3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4};
   localparam logic [2:0] RING_COL [12] = '{3'd1, 3'd3, 3'd5, 3'd7, 3'd0, 3'd2,
                                            3'd4, 3'd6, 3'd1, 3'd3, 3'd5, 3'd7};

   typedef struct packed {
      logic             action;
      logic             err;
      logic             north;
      logic             south;
      logic [PIX_W-1:0] pix;
   } sprnr_item_type;

   function automatic logic [2:0] row_of(input logic [3:0] f);
      if (f < 4'd12) begin
         return RING_ROW[f];
      end
      return RING_ROW[11];
   endfunction

   function automatic logic [2:0] col_of(input logic [3:0] f);
      if (f < 4'd12) begin
         return RING_COL[f];
      end
      return RING_COL[11];
   endfunction

   function automatic logic [31:0] gather64(input logic [63:0] v);
      logic [63:0] r;
      r = v & M1;
      r = (r ^ (r >> 1)) & M2;
      r = (r ^ (r >> 2)) & M4;
      r = (r ^ (r >> 4)) & M8;
      r = (r ^ (r >> 8)) & M16;
      r = (r ^ (r >> 16));
      return r[31:0];
   endfunction

   function automatic logic [63:0] spread32(input logic [31:0] v);
      logic [63:0] r;
      r = {32'd0, v};
      r = (r ^ (r << 16)) & M16;
      r = (r ^ (r << 8)) & M8;
      r = (r ^ (r << 4)) & M4;
      r = (r ^ (r << 2)) & M2;
      r = (r ^ (r << 1)) & M1;
      return r;
   endfunction

endpackage

[src/sprnr_sqrt.sv]
// Pipelined integer square root, one root bit per register stage, with a
// payload that travels alongside. Depends on nothing.
module sprnr_sqrt #(
   parameter int ARG_W = 60,
   parameter int PAY_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [ARG_W-1:0]     in_arg,
   input  logic [PAY_W-1:0]     in_pay,
   output logic                 out_valid,
   output logic [ARG_W/2-1:0]   out_root,
   output logic [PAY_W-1:0]     out_pay
);

   localparam int ROOT_W = ARG_W / 2;
   localparam int REM_W  = ROOT_W + 2;

   logic              valid_ff [ROOT_W];
   logic [ARG_W-1:0]  arg_ff   [ROOT_W];
   logic [REM_W-1:0]  rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [PAY_W-1:0]  pay_ff   [ROOT_W];

   logic              valid_in [ROOT_W];
   logic [ARG_W-1:0]  arg_in   [ROOT_W];
   logic [REM_W-1:0]  rem_in   [ROOT_W];
   logic [ROOT_W-1:0] root_in  [ROOT_W];
   logic [PAY_W-1:0]  pay_in   [ROOT_W];

   // Stage s settles root bit ROOT_W-1-s from the next pair of argument bits.
   always_comb begin
      logic [ARG_W-1:0]  pa;
      logic [REM_W-1:0]  pr;
      logic [ROOT_W-1:0] pq;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic              ge;
      for (int s = 0; s < ROOT_W; s++) begin
         if (s == 0) begin
            valid_in[s] = in_valid;
            pa          = in_arg;
            pr          = '0;
            pq          = '0;
            pay_in[s]   = in_pay;
         end else begin
            valid_in[s] = valid_ff[s-1];
            pa          = arg_ff[s-1];
            pr          = rem_ff[s-1];
            pq          = root_ff[s-1];
            pay_in[s]   = pay_ff[s-1];
         end
         rem_sh     = {pr[ROOT_W-1:0], 2'(pa >> (2 * (ROOT_W - 1 - s)))};
         trial      = {pq, 2'b01};
         ge         = (rem_sh >= trial);
         rem_in[s]  = ge ? (rem_sh - trial) : rem_sh;
         root_in[s] = {pq[ROOT_W-2:0], ge};
         arg_in[s]  = pa;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < ROOT_W; s++) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_in[s];
         end
         arg_ff[s]  <= arg_in[s];
         rem_ff[s]  <= rem_in[s];
         root_ff[s] <= root_in[s];
         pay_ff[s]  <= pay_in[s];
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_pay   = pay_ff[ROOT_W-1];

endmodule

[src/sphere_pixel_nest_ring_convert_core.sv]
// Top level of the sphere pixel nested/ring index converter.
// Depends on sprnr_pkg, sprnr_sqrt and the assertion macro header.
//
// Usage:
//  - A request (req_action, req_pixel_in) is taken at a rising edge with start
//    high and busy low. busy is always low: one request can enter every cycle.
//  - req_action low converts nested to ring, high converts ring to nested.
//  - Each request gives one result on rsp_pixel_out and rsp_error, shown for
//    exactly one cycle with rsp_strobe high. Results leave in request order.
//  - Each result passes through the square root pipeline, which resolves one
//    root bit per stage, plus eight stages of input capture, decode and ring
//    arithmetic.
//  - Throughput is one request per clock cycle.
//  - csr_we with csr_wdata writes the grid side; write it only while no
//    request is in flight. Its reset value is 1.
//  - A grid side that is not a power of two, or a pixel index beyond the grid,
//    gives rsp_error high with rsp_pixel_out zero.
//  - Synchronous reset empties the pipeline; requests in flight are dropped.
//  - The receiver cannot stall, so no request is ever held back.
`include "sphere_pixel_nest_ring_convert_core_assert.svh"
module sphere_pixel_nest_ring_convert_core #(
   parameter int MAX_ORDER = sprnr_pkg::MAX_ORDER_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [sprnr_pkg::PIX_W-1:0]   req_pixel_in,
   output logic                          rsp_strobe,
   output logic [sprnr_pkg::PIX_W-1:0]   rsp_pixel_out,
   output logic                          rsp_error,
   input  logic                          csr_we,
   input  logic [sprnr_pkg::SIDE_W-1:0]  csr_wdata
);

   import sprnr_pkg::*;

   localparam int K_W     = $clog2(MAX_ORDER + 1);
   localparam int S_W     = MAX_ORDER + 5;
   localparam int ARG_W   = 2 * MAX_ORDER + 2;
   localparam int ROOT_W  = MAX_ORDER + 1;
   localparam int M_W     = ROOT_W + 1;
   localparam int LATENCY = ROOT_W + 8;
   localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(1) << MAX_ORDER;
   localparam logic signed [S_W-1:0] ONE_S = S_W'(1);

   // Grid side held as its log2 plus a bad-side flag.
   logic [K_W-1:0] k_ff, k_in;
   logic           bad_ff, bad_in;

   always_comb begin
      k_in = '0;
      for (int i = 0; i < SIDE_W; i++) begin
         if (csr_wdata[i]) begin
            k_in = K_W'(i);
         end
      end
      bad_in = (csr_wdata == '0) || ((csr_wdata & (csr_wdata - 1'b1)) != '0)
               || (csr_wdata > SIDE_MAX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff   <= '0;
         bad_ff <= 1'b0;
      end else if (csr_we) begin
         k_ff   <= k_in;
         bad_ff <= bad_in;
      end
   end

   logic [63:0]           npix64, ncap64, mask2k, n4_64;
   logic signed [S_W-1:0] n_s, n3_s, n4_s;

   assign npix64 = 64'd3 << (2 * k_ff + 2);
   assign ncap64 = (64'd1 << (2 * k_ff + 1)) - (64'd1 << (k_ff + 1));
   assign mask2k = (64'd1 << (2 * k_ff)) - 64'd1;
   assign n4_64  = 64'd4 << k_ff;
   assign n_s    = ONE_S <<< k_ff;
   assign n3_s   = n_s + (n_s <<< 1);
   assign n4_s   = n_s <<< 2;

   assign busy = 1'b0;

   // Stage 0: request capture.
   logic             s0_valid_ff;
   logic             s0_action_ff;
   logic [PIX_W-1:0] s0_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start;
      end
      s0_action_ff <= req_action;
      s0_pix_ff    <= req_pixel_in;
   end

   // Stage 1: range check, ring region and square root argument.
   logic             s1_valid_ff;
   sprnr_item_type   s1_item_ff, s1_item_in;
   logic [ARG_W-1:0] s1_arg_ff, s1_arg_in;

   always_comb begin
      logic [63:0] pix64;
      logic [63:0] arg64;
      pix64             = {2'b00, s0_pix_ff};
      s1_item_in.action = s0_action_ff;
      s1_item_in.pix    = s0_pix_ff;
      s1_item_in.err    = bad_ff || (pix64 >= npix64);
      s1_item_in.north  = (pix64 < ncap64);
      s1_item_in.south  = (pix64 >= (npix64 - ncap64));
      if (s1_item_in.north) begin
         arg64 = (pix64 << 1) + 64'd1;
      end else begin
         arg64 = ((npix64 - pix64) << 1) - 64'd1;
      end
      s1_arg_in = arg64[ARG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
      s1_item_ff <= s1_item_in;
      s1_arg_ff  <= s1_arg_in;
   end

   logic                sq_valid;
   logic [ROOT_W-1:0]   sq_root;
   sprnr_item_type      sq_item;

   sprnr_sqrt #(
      .ARG_W (ARG_W),
      .PAY_W ($bits(sprnr_item_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_arg    (s1_arg_ff),
      .in_pay    (s1_item_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_pay   (sq_item)
   );

   // Stage p1: de-interleave for nested input, ring number for ring input.
   logic                  p1_valid_ff;
   sprnr_item_type        p1_item_ff;
   logic signed [S_W-1:0] p1_x_ff, p1_x_in, p1_y_ff, p1_y_in;
   logic [3:0]            p1_f_ff, p1_f_in;
   logic signed [S_W-1:0] p1_jr_ff, p1_jr_in, p1_jrs_ff, p1_jrs_in;
   logic                  p1_nn_ff, p1_nn_in, p1_ns_ff, p1_ns_in;
   logic signed [S_W-1:0] p1_iring_ff, p1_iring_in, p1_iphi_ff, p1_iphi_in;
   logic [M_W-1:0]        p1_m_ff, p1_m_in;

   always_comb begin
      logic [63:0]           pix64;
      logic [63:0]           low;
      logic [31:0]           xg;
      logic [31:0]           yg;
      logic signed [S_W-1:0] rown;
      logic [ROOT_W:0]       tmp_root;
      logic signed [S_W-1:0] iring_cap;
      logic signed [S_W-1:0] iring_eq;
      logic [63:0]           ip_eq;
      pix64     = {2'b00, sq_item.pix};
      low       = pix64 & mask2k;
      xg        = gather64(low);
      yg        = gather64(low >> 1);
      p1_x_in   = S_W'(xg[MAX_ORDER-1:0]);
      p1_y_in   = S_W'(yg[MAX_ORDER-1:0]);
      p1_f_in   = 4'(pix64 >> (2 * k_ff));
      rown      = S_W'(row_of(p1_f_in)) << k_ff;
      p1_jr_in  = rown - p1_x_in - p1_y_in - ONE_S;
      p1_nn_in  = (p1_jr_in < n_s);
      p1_ns_in  = (p1_jr_in > n3_s);
      p1_jrs_in = p1_ns_in ? (n4_s - p1_jr_in) : p1_jr_in;
      tmp_root  = {1'b0, sq_root} + 1'b1;
      iring_cap = S_W'(tmp_root[ROOT_W:1]);
      ip_eq     = pix64 - ncap64;
      iring_eq  = S_W'(ip_eq >> (k_ff + 2)) + n_s;
      p1_iphi_in = S_W'(ip_eq & (n4_64 - 64'd1)) + ONE_S;
      p1_iring_in = (sq_item.north || sq_item.south) ? iring_cap : iring_eq;
      // The south cap of a nested index counts its ring back from npix by 2 * (jr + 1) * jr.
      if (sq_item.action == ACT_NEST_TO_RING) begin
         if (p1_ns_in) begin
            p1_m_in = M_W'(p1_jrs_in + ONE_S);
         end else begin
            p1_m_in = M_W'(p1_jrs_in);
         end
      end else begin
         p1_m_in = M_W'(p1_iring_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= sq_valid;
      end
      p1_item_ff  <= sq_item;
      p1_x_ff     <= p1_x_in;
      p1_y_ff     <= p1_y_in;
      p1_f_ff     <= p1_f_in;
      p1_jr_ff    <= p1_jr_in;
      p1_jrs_ff   <= p1_jrs_in;
      p1_nn_ff    <= p1_nn_in;
      p1_ns_ff    <= p1_ns_in;
      p1_iring_ff <= p1_iring_in;
      p1_iphi_ff  <= p1_iphi_in;
      p1_m_ff     <= p1_m_in;
   end

   // Stage p2: ring triangle product, column in ring, equatorial face.
   logic                  p2_valid_ff;
   sprnr_item_type        p2_item_ff;
   logic [2*M_W-1:0]      p2_prod_ff, p2_prod_in;
   logic signed [S_W-1:0] p2_jp_ff, p2_jp_in, p2_jr_ff;
   logic                  p2_nn_ff, p2_ns_ff;
   logic signed [S_W-1:0] p2_iring_ff, p2_iphi_ff;
   logic                  p2_kshift_ff, p2_kshift_in;
   logic [3:0]            p2_face_ff, p2_face_in;

   always_comb begin
      logic [M_W-1:0]        m_dec;
      logic signed [S_W-1:0] col_s;
      logic signed [S_W-1:0] t;
      logic signed [S_W-1:0] jp_q;
      logic                  jrn_odd;
      logic signed [S_W-1:0] ire;
      logic signed [S_W-1:0] irm;
      logic signed [S_W-1:0] ifm;
      logic signed [S_W-1:0] ifp;
      m_dec      = p1_m_ff - 1'b1;
      p2_prod_in = p1_m_ff * m_dec;
      col_s      = S_W'(col_of(p1_f_ff));
      jrn_odd    = p1_jr_ff[0] ^ n_s[0];
      if (!p1_nn_ff && !p1_ns_ff) begin
         t = (col_s <<< k_ff) + p1_x_ff - p1_y_ff + ONE_S
             + $signed({{(S_W-1){1'b0}}, jrn_odd});
      end else begin
         t = col_s * p1_jrs_ff + p1_x_ff - p1_y_ff + ONE_S;
      end
      // Halving rounds towards zero.
      jp_q = (t + $signed({{(S_W-1){1'b0}}, t[S_W-1]})) >>> 1;
      if (jp_q > n4_s) begin
         p2_jp_in = jp_q - n4_s;
      end else if (jp_q < ONE_S) begin
         p2_jp_in = jp_q + n4_s;
      end else begin
         p2_jp_in = jp_q;
      end
      p2_kshift_in = p1_iring_ff[0] ^ n_s[0];
      ire = p1_iring_ff - n_s + ONE_S;
      irm = (n_s <<< 1) + (ONE_S <<< 1) - ire;
      ifm = (p1_iphi_ff - (ire >>> 1) + n_s - ONE_S) >>> k_ff;
      ifp = (p1_iphi_ff - (irm >>> 1) + n_s - ONE_S) >>> k_ff;
      if (ifp == ifm) begin
         p2_face_in = ifp[3:0] | 4'd4;
      end else if (ifp < ifm) begin
         p2_face_in = ifp[3:0];
      end else begin
         p2_face_in = ifm[3:0] + 4'd8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff;
      end
      p2_item_ff   <= p1_item_ff;
      p2_prod_ff   <= p2_prod_in;
      p2_jp_ff     <= p2_jp_in;
      p2_jr_ff     <= p1_jr_ff;
      p2_nn_ff     <= p1_nn_ff;
      p2_ns_ff     <= p1_ns_ff;
      p2_iring_ff  <= p1_iring_ff;
      p2_iphi_ff   <= p1_iphi_ff;
      p2_kshift_ff <= p2_kshift_in;
      p2_face_ff   <= p2_face_in;
   end

   // Stage p3: ring index for nested input, position in ring for ring input.
   logic                  p3_valid_ff;
   sprnr_item_type        p3_item_ff;
   logic [PIX_W-1:0]      p3_ring_ff, p3_ring_in;
   logic signed [S_W-1:0] p3_iphi_ff, p3_iphi_in, p3_iring_ff;
   logic                  p3_kshift_ff;
   logic [3:0]            p3_face_ff;

   always_comb begin
      logic [63:0] pix64;
      logic [63:0] prod64;
      logic [63:0] jp64;
      logic [63:0] jrmn64;
      logic [63:0] iring64;
      logic [63:0] sum64;
      logic [63:0] iphi64;
      logic signed [S_W-1:0] jrmn;
      pix64   = {2'b00, p2_item_ff.pix};
      prod64  = 64'(p2_prod_ff);
      jp64    = {{(64-S_W){p2_jp_ff[S_W-1]}}, p2_jp_ff};
      jrmn    = p2_jr_ff - n_s;
      jrmn64  = {{(64-S_W){jrmn[S_W-1]}}, jrmn};
      iring64 = {{(64-S_W){p2_iring_ff[S_W-1]}}, p2_iring_ff};
      if (p2_nn_ff) begin
         sum64 = (prod64 << 1) + jp64 - 64'd1;
      end else if (p2_ns_ff) begin
         sum64 = npix64 - (prod64 << 1) + jp64 - 64'd1;
      end else begin
         sum64 = ncap64 + (jrmn64 << (k_ff + 2)) + jp64 - 64'd1;
      end
      p3_ring_in = sum64[PIX_W-1:0];
      if (p2_item_ff.north) begin
         iphi64 = pix64 + 64'd1 - (prod64 << 1);
      end else begin
         iphi64 = (iring64 << 2) + 64'd1 - (npix64 - pix64 - (prod64 << 1));
      end
      if (p2_item_ff.north || p2_item_ff.south) begin
         p3_iphi_in = S_W'(iphi64);
      end else begin
         p3_iphi_in = p2_iphi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff <= p2_valid_ff;
      end
      p3_item_ff   <= p2_item_ff;
      p3_ring_ff   <= p3_ring_in;
      p3_iphi_ff   <= p3_iphi_in;
      p3_iring_ff  <= p2_iring_ff;
      p3_kshift_ff <= p2_kshift_ff;
      p3_face_ff   <= p2_face_ff;
   end

   // Stage p4: base face for the polar caps.
   logic                  p4_valid_ff;
   sprnr_item_type        p4_item_ff;
   logic [PIX_W-1:0]      p4_ring_ff;
   logic signed [S_W-1:0] p4_iphi_ff, p4_iring_ff;
   logic                  p4_kshift_ff;
   logic [3:0]            p4_face_ff, p4_face_in;

   always_comb begin
      logic signed [S_W-1:0] d;
      logic signed [S_W-1:0] i2;
      logic signed [S_W-1:0] i3;
      logic [3:0]            q;
      d  = p3_iphi_ff - ONE_S;
      i2 = p3_iring_ff <<< 1;
      i3 = i2 + p3_iring_ff;
      if (d >= i3) begin
         q = 4'd3;
      end else if (d >= i2) begin
         q = 4'd2;
      end else if (d >= p3_iring_ff) begin
         q = 4'd1;
      end else begin
         q = 4'd0;
      end
      if (p3_item_ff.north) begin
         p4_face_in = q;
      end else if (p3_item_ff.south) begin
         p4_face_in = q + 4'd8;
      end else begin
         p4_face_in = p3_face_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else begin
         p4_valid_ff <= p3_valid_ff;
      end
      p4_item_ff   <= p3_item_ff;
      p4_ring_ff   <= p3_ring_ff;
      p4_iphi_ff   <= p3_iphi_ff;
      p4_iring_ff  <= p3_iring_ff;
      p4_kshift_ff <= p3_kshift_ff;
      p4_face_ff   <= p4_face_in;
   end

   // Stage p5: face-local row and column offsets.
   logic                  p5_valid_ff;
   sprnr_item_type        p5_item_ff;
   logic [PIX_W-1:0]      p5_ring_ff;
   logic [3:0]            p5_face_ff;
   logic signed [S_W-1:0] p5_irt_ff, p5_irt_in, p5_ipt_ff, p5_ipt_in;

   always_comb begin
      logic signed [S_W-1:0] rown;
      logic signed [S_W-1:0] col_s;
      logic signed [S_W-1:0] ipt0;
      rown  = S_W'(row_of(p4_face_ff)) << k_ff;
      col_s = S_W'(col_of(p4_face_ff));
      if (p4_item_ff.south) begin
         p5_irt_in = n4_s - p4_iring_ff - rown + ONE_S;
      end else begin
         p5_irt_in = p4_iring_ff - rown + ONE_S;
      end
      if (p4_item_ff.north || p4_item_ff.south) begin
         ipt0 = (p4_iphi_ff <<< 1) - col_s * p4_iring_ff - ONE_S;
      end else begin
         ipt0 = (p4_iphi_ff <<< 1) - (col_s <<< k_ff)
                - $signed({{(S_W-1){1'b0}}, p4_kshift_ff}) - ONE_S;
      end
      if (ipt0 >= (n_s <<< 1)) begin
         p5_ipt_in = ipt0 - (n_s <<< 3);
      end else begin
         p5_ipt_in = ipt0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_valid_ff <= 1'b0;
      end else begin
         p5_valid_ff <= p4_valid_ff;
      end
      p5_item_ff <= p4_item_ff;
      p5_ring_ff <= p4_ring_ff;
      p5_face_ff <= p4_face_ff;
      p5_irt_ff  <= p5_irt_in;
      p5_ipt_ff  <= p5_ipt_in;
   end

   // Stage p6: interleave x and y into the nested index, select the result.
   logic             rsp_strobe_ff;
   logic [PIX_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic             rsp_error_ff;

   always_comb begin
      logic signed [S_W-1:0] xd;
      logic signed [S_W-1:0] yd;
      logic signed [S_W-1:0] xs;
      logic signed [S_W-1:0] ys;
      logic [63:0]           x64;
      logic [63:0]           y64;
      logic [63:0]           nest64;
      xd     = p5_ipt_ff - p5_irt_ff;
      yd     = -(p5_ipt_ff + p5_irt_ff);
      xs     = xd >>> 1;
      ys     = yd >>> 1;
      x64    = {{(64-S_W){xs[S_W-1]}}, xs};
      y64    = {{(64-S_W){ys[S_W-1]}}, ys};
      nest64 = (64'(p5_face_ff) << (2 * k_ff)) + spread32(x64[31:0])
               + (spread32(y64[31:0]) << 1);
      if (p5_item_ff.err) begin
         rsp_pixel_in = '0;
      end else if (p5_item_ff.action == ACT_RING_TO_NEST) begin
         rsp_pixel_in = nest64[PIX_W-1:0];
      end else begin
         rsp_pixel_in = p5_ring_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= p5_valid_ff;
      end
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_error_ff <= p5_item_ff.err;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_error     = rsp_error_ff;

   `SPRNR_ASSERT_DELAY(a_latency, start && !busy, LATENCY, rsp_strobe, "result missing")
   `SPRNR_ASSERT_DELAY(a_no_spurious, !start, LATENCY, !rsp_strobe, "spurious result")
   `SPRNR_ASSERT_DELAY(a_sqrt_align, s1_valid_ff && s1_item_ff.err, ROOT_W,
      sq_valid && sq_item.err, "square root payload out of step")
   `SPRNR_ASSERT_NOW(a_err_zero, rsp_strobe && rsp_error, rsp_pixel_out == '0,
      "error result not zero")

endmodule

[verif/sphere_pixel_nest_ring_convert_core_checker.sv]
`timescale 1ns / 1ps
// Checker for the sphere pixel nested/ring converter: follows the grid side
// written on the csr port, predicts each request's result and compares it.
// Depends on sprnr_pkg for widths and action codes.
module sphere_pixel_nest_ring_convert_core_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_action,
   input  logic [sprnr_pkg::PIX_W-1:0]   req_pixel_in,
   input  logic                          rsp_strobe,
   input  logic [sprnr_pkg::PIX_W-1:0]   rsp_pixel_out,
   input  logic                          rsp_error,
   input  logic                          csr_we,
   input  logic [sprnr_pkg::SIDE_W-1:0]  csr_wdata,
   output int                            fail_count,
   output int                            pending
);
   import sprnr_pkg::*;

   typedef struct {
      logic [PIX_W-1:0] pixel;
      logic             err;
   } converted_t;

   converted_t        converted_q[$];
   logic [SIDE_W-1:0] side;

   function automatic longint face_row(longint f);
      if (f < 4) begin
         return 2;
      end else if (f < 8) begin
         return 3;
      end
      return 4;
   endfunction

   // Odd columns for the polar faces, even ones for the equatorial faces.
   function automatic longint face_col(longint f);
      if (f < 4) begin
         return 2 * f + 1;
      end else if (f < 8) begin
         return 2 * (f - 4);
      end else if (f < 12) begin
         return 2 * (f - 8) + 1;
      end
      return 7;
   endfunction

   function automatic longint odd_bits(longint unsigned v);
      longint unsigned r;
      r = 0;
      for (int i = 0; i < 32; i++) r[i] = v[2 * i];
      return longint'(r);
   endfunction

   function automatic longint unsigned even_spread(longint unsigned v);
      longint unsigned r;
      r = 0;
      for (int i = 0; i < 32; i++) r[2 * i] = v[i];
      return r;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint wrap_phi(longint jp, longint nl4);
      if (jp > nl4) begin
         return jp - nl4;
      end else if (jp < 1) begin
         return jp + nl4;
      end
      return jp;
   endfunction

   function automatic longint to_ring(longint n, longint pix);
      longint fpx, low, x, y, f, nl4, jr, jp;
      fpx = n * n;
      low = pix & (fpx - 1);
      x   = odd_bits(low);
      y   = odd_bits(low >> 1);
      f   = pix / fpx;
      nl4 = 4 * n;
      jr  = face_row(f) * n - x - y - 1;
      if (jr < n) begin
         jp = wrap_phi((face_col(f) * jr + x - y + 1) / 2, nl4);
         return 2 * jr * (jr - 1) + jp - 1;
      end
      if (jr > 3 * n) begin
         jr = nl4 - jr;
         jp = wrap_phi((face_col(f) * jr + x - y + 1) / 2, nl4);
         return 12 * n * n - 2 * (jr + 1) * jr + jp - 1;
      end
      jp = wrap_phi((face_col(f) * n + x - y + 1 + ((jr - n) & 1)) / 2, nl4);
      return 2 * n * (n - 1) + (jr - n) * nl4 + jp - 1;
   endfunction

   function automatic longint to_nest(longint n, longint pix);
      longint ncap, npix, face, irt, ipt, ring, phi, ip, kshift, ire, irm, ifm, ifp, x, y;
      ncap = 2 * n * (n - 1);
      npix = 12 * n * n;
      if (pix < ncap) begin
         ring = longint'((1 + root_floor(1 + 2 * pix)) >> 1);
         phi  = pix + 1 - 2 * ring * (ring - 1);
         face = (phi - 1) / ring;
         irt  = ring - face_row(face) * n + 1;
         ipt  = 2 * phi - face_col(face) * ring - 1;
      end else if (pix < npix - ncap) begin
         ip     = pix - ncap;
         ring   = ip / (4 * n) + n;
         phi    = ip % (4 * n) + 1;
         kshift = (ring + n) & 1;
         ire    = ring - n + 1;
         irm    = 2 * n + 2 - ire;
         ifm    = (phi - ire / 2 + n - 1) / n;
         ifp    = (phi - irm / 2 + n - 1) / n;
         if (ifp == ifm) begin
            face = ifp | 4;
         end else if (ifp < ifm) begin
            face = ifp;
         end else begin
            face = ifm + 8;
         end
         irt = ring - face_row(face) * n + 1;
         ipt = 2 * phi - face_col(face) * n - kshift - 1;
      end else begin
         ip   = npix - pix;
         ring = longint'((1 + root_floor(2 * ip - 1)) >> 1);
         phi  = 4 * ring + 1 - (ip - 2 * ring * (ring - 1));
         face = 8 + (phi - 1) / ring;
         irt  = 4 * n - ring - face_row(face) * n + 1;
         ipt  = 2 * phi - face_col(face) * ring - 1;
      end
      if (ipt >= 2 * n) ipt = ipt - 8 * n;
      // Arithmetic shift gives the floor of a halving for negative values too.
      x = (ipt - irt) >>> 1;
      y = (-(ipt + irt)) >>> 1;
      return face * n * n + longint'(even_spread(x)) + longint'(even_spread(y) << 1);
   endfunction

   function automatic converted_t convert(logic act, logic [PIX_W-1:0] pix,
                                          logic [SIDE_W-1:0] sd);
      converted_t        c;
      longint unsigned   n;
      longint            r;
      n       = 64'(sd);
      c.pixel = '0;
      c.err   = 1'b0;
      if (n == 0 || (n & (n - 1)) != 0 || n > (64'd1 << MAX_ORDER_DEF)) begin
         c.err = 1'b1;
      end else if (64'(pix) >= 12 * n * n) begin
         c.err = 1'b1;
      end else begin
         if (act == ACT_NEST_TO_RING) begin
            r = to_ring(longint'(n), longint'(64'(pix)));
         end else begin
            r = to_nest(longint'(n), longint'(64'(pix)));
         end
         c.pixel = r[PIX_W-1:0];
      end
      return c;
   endfunction

   task automatic report(string what);
      $display("%0t mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      converted_t want;
      if (reset) begin
         side <= 1;
         converted_q.delete();
      end else begin
         if (rsp_strobe) begin
            if (converted_q.size() == 0) begin
               report($sformatf("result %h/%b with no request waiting", rsp_pixel_out,
                                rsp_error));
            end else begin
               want = converted_q.pop_front();
               if (rsp_pixel_out !== want.pixel)
                  report($sformatf("pixel_out %h, predicted %h", rsp_pixel_out, want.pixel));
               if (rsp_error !== want.err)
                  report($sformatf("error %b, predicted %b", rsp_error, want.err));
            end
         end
         if (start && !busy) converted_q.push_back(convert(req_action, req_pixel_in, side));
         if (csr_we) side <= csr_wdata;
      end
      pending = converted_q.size();
   end

endmodule

[verif/sphere_pixel_nest_ring_convert_core_tb.sv]
`timescale 1ns / 1ps
// Top of the sphere pixel nested/ring converter testbench: clock, reset,
// request stimulus over several grid sides and the verdict. Depends on
// sprnr_pkg, the converter RTL and sphere_pixel_nest_ring_convert_core_checker.
module sphere_pixel_nest_ring_convert_core_tb;
   import sprnr_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_action = ACT_NEST_TO_RING;
   logic [PIX_W-1:0]  req_pixel_in = '0;
   logic              rsp_strobe;
   logic [PIX_W-1:0]  rsp_pixel_out;
   logic              rsp_error;
   logic              csr_we = 1'b0;
   logic [SIDE_W-1:0] csr_wdata = '0;
   int                fail_count;
   int                pending;
   int                burst_left = 0;

   always #2 clock = ~clock;

   sphere_pixel_nest_ring_convert_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_pixel_in(req_pixel_in),
      .rsp_strobe(rsp_strobe), .rsp_pixel_out(rsp_pixel_out), .rsp_error(rsp_error),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   sphere_pixel_nest_ring_convert_core_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_pixel_in(req_pixel_in),
      .rsp_strobe(rsp_strobe), .rsp_pixel_out(rsp_pixel_out), .rsp_error(rsp_error),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(logic act, logic [PIX_W-1:0] pix);
      if (burst_left == 0) begin
         start = 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      start        = 1'b1;
      req_action   = act;
      req_pixel_in = pix;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Drains the pipeline, lets the latency pass, then writes a new grid side.
   task automatic set_side(logic [SIDE_W-1:0] sd);
      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (48) @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = sd;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic random_requests(int count, longint unsigned n);
      longint unsigned npix, ncap, pick;
      int              kind;
      npix = 12 * n * n;
      ncap = 2 * n * (n - 1);
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 99);
         pick = {$urandom, $urandom};
         if (kind < 80 && npix != 0) begin
            pick = pick % npix;
         end else if (kind < 90 && npix != 0) begin
            case ($urandom_range(0, 5))
               0: pick = ncap == 0 ? 0 : ncap - 1;
               1: pick = ncap;
               2: pick = npix - ncap - 1;
               3: pick = npix - ncap;
               4: pick = npix - 1;
               default: pick = npix;
            endcase
         end
         send_request(1'($urandom_range(0, 1)), pick[PIX_W-1:0]);
      end
   endtask

   initial begin
      logic [SIDE_W-1:0] sides[$];
      longint unsigned   edges[$];
      longint unsigned   n, npix, ncap;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed pass at a small grid: ends of the range and cap boundaries.
      set_side(4);
      n    = 4;
      npix = 12 * n * n;
      ncap = 2 * n * (n - 1);
      edges = '{0, npix - 1, npix, 64'h3fffffffffffffff, ncap - 1, ncap,
                npix - ncap - 1, npix - ncap};
      foreach (edges[i]) begin
         send_request(ACT_NEST_TO_RING, edges[i][PIX_W-1:0]);
         send_request(ACT_RING_TO_NEST, edges[i][PIX_W-1:0]);
      end

      sides = '{1, 2, 30'h20000000, 0, 3, 30'h3fffffff, 8, 16, 1024, 30'h100000,
                30'h20000001, 64, 30'd1 << $urandom_range(0, 29)};
      foreach (sides[i]) begin
         set_side(sides[i]);
         random_requests(64, 64'(sides[i]));
      end

      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (48) @(negedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/sprnr_pkg.sv
src/sprnr_sqrt.sv
src/sphere_pixel_nest_ring_convert_core.sv
verif/sphere_pixel_nest_ring_convert_core_checker.sv
verif/sphere_pixel_nest_ring_convert_core_tb.sv
